FILE: rtl/tdim_pkg.sv
// Package for the phase-angle triac dimmer: word types, command codes,
// register indexes and reset constants. No dependencies.
package tdim_pkg;

    // Default values for the top-level parameters
    localparam int MAX_LEVEL_DEF   = 255;
    localparam int DELAY_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int LEVEL_BITS  = 8;
    localparam int TICK_BITS   = 16;
    localparam int CFG_IDX_W   = 2;

    // Register reset values
    localparam logic             NEUTRAL_RESET   = 1'b1;
    localparam logic [TICK_BITS-1:0] MIN_DELAY_RESET = 16'd500;
    localparam logic [TICK_BITS-1:0] SPAN_RESET      = 16'd37500;
    localparam logic [TICK_BITS-1:0] NN_THRESH_RESET = 16'd20000;

    // Toggle rule and indicator intensities
    localparam logic [LEVEL_BITS-1:0] TOGGLE_THRESHOLD = 8'd25;
    localparam logic [LEVEL_BITS-1:0] TOGGLE_ON_LEVEL  = 8'd255;
    localparam logic [LEVEL_BITS-1:0] LED_FULL         = 8'hFF;
    localparam logic [LEVEL_BITS-1:0] LED_DARK         = 8'h00;

    // Event codes carried in the input word
    typedef enum logic [2:0] {
        MODE_TICK       = 3'd0,
        MODE_ZERO_CROSS = 3'd1,
        MODE_SET        = 3'd2,
        MODE_INC        = 3'd3,
        MODE_DEC        = 3'd4,
        MODE_ON         = 3'd5,
        MODE_OFF        = 3'd6,
        MODE_TOGGLE     = 3'd7
    } mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEUTRAL   = 2'd0,
        CFG_MIN_DELAY = 2'd1,
        CFG_SPAN      = 2'd2,
        CFG_NN_THRESH = 2'd3
    } cfg_index_t;

    typedef struct packed {
        mode_t                 mode;
        logic [LEVEL_BITS-1:0] value;
        logic                  storage_busy;
    } in_word_t;

    typedef struct packed {
        logic                  triac_gate;
        logic [LEVEL_BITS-1:0] stored_level;
        logic [LEVEL_BITS-1:0] applied_level;
        logic [LEVEL_BITS-1:0] led_red;
        logic [LEVEL_BITS-1:0] led_green;
        logic [LEVEL_BITS-1:0] led_blue;
    } out_word_t;

endpackage

FILE: rtl/triac_phase_dimmer_top.sv
// Top level of the phase-angle triac dimmer: input register, event logic,
// dimmer state and result register. Depends on tdim_pkg.
//
//  channel  | ports                           | word
//  ---------+---------------------------------+----------------------
//  input    | s_valid, s_ready, s_data        | tdim_pkg::in_word_t
//  result   | m_valid, m_ready, m_data        | tdim_pkg::out_word_t
//  config   | cfg_we, cfg_addr, cfg_wdata     | 16-bit register write
//
// One word per cycle sustained while m_ready is high; each word is held in
// the input register and its result is registered in the result register.
// The firing delay comes from one 16 x (16+level bits) multiply against a
// reciprocal table, done in the same cycle as the event logic.
// Reset (aresetn low, synchronous) restores full-on level and registers.
// With m_ready low the result holds, one more word waits in the input
// register, then s_ready drops.
module triac_phase_dimmer_top #(
    parameter int MAX_LEVEL   = tdim_pkg::MAX_LEVEL_DEF,
    parameter int DELAY_WIDTH = tdim_pkg::DELAY_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tdim_pkg::in_word_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tdim_pkg::out_word_t                 m_data,
    input  logic                                cfg_we,
    input  logic [tdim_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [tdim_pkg::TICK_BITS-1:0]      cfg_wdata
);
    import tdim_pkg::*;

    localparam int LEVEL_W   = $clog2(MAX_LEVEL + 1);
    localparam int IDX_W     = $clog2(MAX_LEVEL);
    // Enough fraction bits that span * error stays below 1/MAX_LEVEL
    localparam int FRAC_BITS = TICK_BITS + LEVEL_W;
    localparam int PROD_W    = TICK_BITS + FRAC_BITS;
    localparam int SUM_W     = TICK_BITS + 1;
    localparam int CMP_W     = (DELAY_WIDTH > SUM_W) ? DELAY_WIDTH : SUM_W;
    localparam int THR_W     = (DELAY_WIDTH > TICK_BITS) ? DELAY_WIDTH : TICK_BITS;

    localparam logic [LEVEL_W-1:0]     LEVEL_MAX   = LEVEL_W'(MAX_LEVEL);
    localparam logic [DELAY_WIDTH-1:0] DELAY_RESET = DELAY_WIDTH'(32'hFFFF);
    localparam logic [CMP_W-1:0]       DELAY_SAT   = CMP_W'({DELAY_WIDTH{1'b1}});
    localparam logic [LEVEL_W-1:0]     TOGGLE_ON   =
        (TOGGLE_ON_LEVEL > LEVEL_BITS'(MAX_LEVEL)) ? LEVEL_MAX : LEVEL_W'(TOGGLE_ON_LEVEL);

    // Configuration registers
    logic                 neutral_reg;
    logic [TICK_BITS-1:0] min_delay_reg;
    logic [TICK_BITS-1:0] span_reg;
    logic [TICK_BITS-1:0] nn_thresh_reg;

    // Pipeline registers
    logic      in_valid_reg, in_valid_next;
    in_word_t  in_word_reg;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg, out_word_next;
    logic      advance;

    // Dimmer state
    logic [LEVEL_W-1:0]     level_store_reg, level_store_next;
    logic [LEVEL_W-1:0]     drive_level_reg, drive_level_next;
    logic [DELAY_WIDTH-1:0] fire_delay_reg, fire_delay_next;
    logic [DELAY_WIDTH-1:0] delay_count_reg, delay_count_next;
    logic                   running_reg, running_next;
    logic                   seen_reg, seen_next;
    logic                   gate_reg, gate_next;
    logic [LEVEL_BITS-1:0]  led_r_reg, led_r_next;
    logic [LEVEL_BITS-1:0]  led_g_reg, led_g_next;
    logic [LEVEL_BITS-1:0]  led_b_reg, led_b_next;

    // Event working signals
    logic                   do_apply;
    logic                   keep_store;
    logic [LEVEL_W-1:0]     cmd_level;
    logic [LEVEL_W-1:0]     dim;
    logic [LEVEL_BITS:0]    inc_sum;
    logic [LEVEL_BITS-1:0]  store_ext;
    logic [DELAY_WIDTH-1:0] count_inc;
    logic [FRAC_BITS-1:0]   recip;
    logic [PROD_W-1:0]      span_prod;
    logic [SUM_W-1:0]       delay_sum;
    logic [CMP_W-1:0]       delay_sum_ext;
    logic [DELAY_WIDTH-1:0] new_delay;

    // Reciprocal table: ceil(d * 2^FRAC_BITS / MAX_LEVEL), fixed at elaboration
    logic [FRAC_BITS-1:0] recip_lut [MAX_LEVEL];
    for (genvar d = 0; d < MAX_LEVEL; d++) begin : g_recip
        assign recip_lut[d] = FRAC_BITS'(((longint'(d) << FRAC_BITS) + MAX_LEVEL - 1)
                                         / MAX_LEVEL);
    end

    // Handshake: the input stage moves on when the result register is free
    assign advance        = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || advance;
    assign in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);
    assign m_valid        = out_valid_reg;
    assign m_data         = out_word_reg;

    // Firing delay for the commanded level: min + floor(span * dim / MAX)
    assign dim           = LEVEL_MAX - cmd_level;
    assign recip         = recip_lut[dim[IDX_W-1:0]];
    assign span_prod     = PROD_W'(span_reg) * PROD_W'(recip);
    assign delay_sum     = SUM_W'(min_delay_reg) + SUM_W'(span_prod[FRAC_BITS +: TICK_BITS]);
    assign delay_sum_ext = CMP_W'(delay_sum);
    assign new_delay     = (delay_sum_ext > DELAY_SAT) ? DELAY_WIDTH'(DELAY_SAT)
                                                       : DELAY_WIDTH'(delay_sum_ext);

    assign store_ext = LEVEL_BITS'(level_store_reg);
    assign inc_sum   = {1'b0, store_ext} + {1'b0, in_word_reg.value};
    assign count_inc = delay_count_reg + 1'b1;

    // Event decode and state update
    always_comb begin
        level_store_next = level_store_reg;
        drive_level_next = drive_level_reg;
        fire_delay_next  = fire_delay_reg;
        delay_count_next = delay_count_reg;
        running_next     = running_reg;
        seen_next        = seen_reg;
        gate_next        = gate_reg;
        led_r_next       = led_r_reg;
        led_g_next       = led_g_reg;
        led_b_next       = led_b_reg;
        do_apply         = 1'b0;
        keep_store       = 1'b0;
        cmd_level        = '0;

        unique case (in_word_reg.mode)
            MODE_TICK: begin
                if (running_reg) begin
                    if (count_inc >= fire_delay_reg) begin
                        delay_count_next = '0;
                        if (!in_word_reg.storage_busy) begin
                            gate_next = (drive_level_reg != '0);
                        end
                    end else begin
                        delay_count_next = count_inc;
                    end
                end
            end
            MODE_ZERO_CROSS: begin
                if (drive_level_reg < LEVEL_MAX) begin
                    gate_next = 1'b0;
                end
                delay_count_next = '0;
                running_next     = 1'b1;
                seen_next        = 1'b1;
            end
            MODE_SET: begin
                do_apply  = 1'b1;
                cmd_level = (in_word_reg.value > LEVEL_BITS'(MAX_LEVEL))
                            ? LEVEL_MAX : LEVEL_W'(in_word_reg.value);
            end
            MODE_INC: begin
                do_apply  = 1'b1;
                cmd_level = (inc_sum > (LEVEL_BITS + 1)'(MAX_LEVEL))
                            ? LEVEL_MAX : LEVEL_W'(inc_sum);
            end
            MODE_DEC: begin
                do_apply  = 1'b1;
                cmd_level = (in_word_reg.value > store_ext)
                            ? '0 : LEVEL_W'(store_ext - in_word_reg.value);
            end
            MODE_ON: begin
                do_apply  = 1'b1;
                cmd_level = (level_store_reg == '0) ? LEVEL_MAX : level_store_reg;
            end
            MODE_OFF: begin
                // level is remembered, only the drive goes to zero
                do_apply   = 1'b1;
                keep_store = 1'b1;
                cmd_level  = '0;
            end
            MODE_TOGGLE: begin
                do_apply  = 1'b1;
                cmd_level = (store_ext > TOGGLE_THRESHOLD) ? '0 : TOGGLE_ON;
            end
        endcase

        if (do_apply) begin
            // no-neutral keepalive works on the delay held before this change
            if (!neutral_reg) begin
                if (THR_W'(fire_delay_reg) < THR_W'(nn_thresh_reg)) begin
                    seen_next = 1'b0;
                end else if (!seen_reg) begin
                    gate_next = 1'b0;
                end
            end
            if (cmd_level == '0) begin
                gate_next  = 1'b0;
                led_r_next = LED_FULL;
                led_g_next = LED_DARK;
                led_b_next = LED_DARK;
            end else if (cmd_level == LEVEL_MAX) begin
                gate_next  = 1'b1;
                led_r_next = LED_DARK;
                led_g_next = LED_FULL;
                led_b_next = LED_DARK;
            end else begin
                fire_delay_next = new_delay;
                led_r_next      = LEVEL_BITS'(dim);
                led_g_next      = LEVEL_BITS'(dim);
                led_b_next      = LEVEL_BITS'(dim);
            end
            drive_level_next = cmd_level;
            if (!keep_store) begin
                level_store_next = cmd_level;
            end
        end

        out_word_next.triac_gate    = gate_next;
        out_word_next.stored_level  = LEVEL_BITS'(level_store_next);
        out_word_next.applied_level = LEVEL_BITS'(drive_level_next);
        out_word_next.led_red       = led_r_next;
        out_word_next.led_green     = led_g_next;
        out_word_next.led_blue      = led_b_next;
    end

    // Control, configuration and dimmer state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            neutral_reg     <= NEUTRAL_RESET;
            min_delay_reg   <= MIN_DELAY_RESET;
            span_reg        <= SPAN_RESET;
            nn_thresh_reg   <= NN_THRESH_RESET;
            level_store_reg <= LEVEL_MAX;
            drive_level_reg <= LEVEL_MAX;
            fire_delay_reg  <= DELAY_RESET;
            delay_count_reg <= '0;
            running_reg     <= 1'b0;
            seen_reg        <= 1'b0;
            gate_reg        <= 1'b1;
            led_r_reg       <= LED_DARK;
            led_g_reg       <= LED_FULL;
            led_b_reg       <= LED_DARK;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                unique case (cfg_index_t'(cfg_addr))
                    CFG_NEUTRAL:   neutral_reg   <= cfg_wdata[0];
                    CFG_MIN_DELAY: min_delay_reg <= cfg_wdata;
                    CFG_SPAN:      span_reg      <= cfg_wdata;
                    CFG_NN_THRESH: nn_thresh_reg <= cfg_wdata;
                endcase
            end
            if (advance) begin
                level_store_reg <= level_store_next;
                drive_level_reg <= drive_level_next;
                fire_delay_reg  <= fire_delay_next;
                delay_count_reg <= delay_count_next;
                running_reg     <= running_next;
                seen_reg        <= seen_next;
                gate_reg        <= gate_next;
                led_r_reg       <= led_r_next;
                led_g_reg       <= led_g_next;
                led_b_reg       <= led_b_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
        if (advance) begin
            out_word_reg <= out_word_next;
        end
    end

    // A word leaving the input stage always shows up as a result
    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced word did not reach result register");

    // The counter only moves once a zero crossing has started it
    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> (delay_count_reg == '0))
        else $error("delay counter moved while stopped");

    // A powered-off or zero-level dimmer never drives the gate, and shows red
    a_off_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        (drive_level_reg == '0) |-> (!gate_reg && led_r_reg == LED_FULL
                                     && led_g_reg == LED_DARK))
        else $error("gate or indicator wrong at zero drive");

    // Full level keeps the gate on
    a_full_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        (drive_level_reg == LEVEL_MAX) |-> gate_reg)
        else $error("gate off at full level");

endmodule
